[src/assert_macros.svh]
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms for the deque RTL.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on the same edge, disabled during reset.
`define CDQ_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked on the following edge, disabled during reset.
`define CDQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/cdq_pkg.sv]
// ============================================================================
// cdq_pkg
// Types, codes and default sizes shared by the deque files.
// ============================================================================
package cdq_pkg;

  localparam int DEPTH_DEF  = 16;
  localparam int DATA_W_DEF = 32;

  localparam int OP_W  = 2;
  localparam int ST_W  = 2;
  localparam int CFG_W = 5;
  localparam int CNT_W = 5;

  typedef logic [OP_W-1:0] op_t;
  typedef logic [ST_W-1:0] status_t;

  localparam op_t OP_PUSH_FRONT = 2'd0;
  localparam op_t OP_PUSH_REAR  = 2'd1;
  localparam op_t OP_POP_FRONT  = 2'd2;
  localparam op_t OP_POP_REAR   = 2'd3;

  localparam status_t STAT_DONE  = 2'd0;
  localparam status_t STAT_FULL  = 2'd1;
  localparam status_t STAT_EMPTY = 2'd2;

  localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

endpackage

[src/cdq_in_if.sv]
// ============================================================================
// cdq_in_if
// Operation request channel: opcode and push word with valid/ready.
// ============================================================================
interface cdq_in_if #(
  parameter int DATA_WIDTH = cdq_pkg::DATA_W_DEF
) ();
  logic                  valid;
  logic                  ready;
  cdq_pkg::op_t          opcode;
  logic [DATA_WIDTH-1:0] push_value;

  modport source (output valid, output opcode, output push_value, input ready);
  modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

[src/cdq_out_if.sv]
// ============================================================================
// cdq_out_if
// Operation result channel: status, popped word, count and flags.
// ============================================================================
interface cdq_out_if #(
  parameter int DATA_WIDTH = cdq_pkg::DATA_W_DEF
) ();
  logic                      valid;
  logic                      ready;
  cdq_pkg::status_t          status;
  logic [DATA_WIDTH-1:0]     popped_value;
  logic [cdq_pkg::CNT_W-1:0] element_count;
  logic                      is_full;
  logic                      is_empty;

  modport source (output valid, output status, output popped_value, output element_count,
                  output is_full, output is_empty, input ready);
  modport sink   (input valid, input status, input popped_value, input element_count,
                  input is_full, input is_empty, output ready);
endinterface

[src/cdq_ram.sv]
// ============================================================================
// cdq_ram
// Single-port ring store with a registered read, one access per cycle.
// ============================================================================
module cdq_ram #(
  parameter int DEPTH      = cdq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = cdq_pkg::DATA_W_DEF,
  localparam int IDX_W     = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic                  rd_en,
  input  logic [IDX_W-1:0]      addr,
  input  logic [DATA_WIDTH-1:0] wr_data,
  output logic [DATA_WIDTH-1:0] rd_data
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[addr];
    end
  end

endmodule

[src/circular_double_ended_queue.sv]
// ============================================================================
// circular_double_ended_queue
// Ring-buffer deque with push/pop at both ends and a settable capacity.
// ============================================================================
// Usage:
//   in_ch carries one operation per transaction: opcode (push front, push
//   rear, pop front, pop rear) and push_value. out_ch returns one result per
//   operation: status, popped_value, element_count, is_full and is_empty.
//   cfg_wr_en/cfg_wr_data write the capacity in use (0 acts as 1, values
//   above DEPTH act as DEPTH); write it only while no operation is pending.
// Timing:
//   An accepted operation reaches the output register through the registered
//   read of the ring memory and the collect state. The controller accepts an
//   operation, then collects the memory read in the collect state before it
//   takes the next one, so a new operation is never taken before the previous
//   one has reached the output register.
// Stalls:
//   While out_ch is stalled the output register holds its result; the next
//   operation is still accepted and waits in the collect state until the
//   output register frees up, and in_ch.ready stays low meanwhile.
// Reset:
//   rst_n (synchronous, active low) empties the deque, zeroes both indices
//   and restores a capacity of 16. Memory contents are not cleared.
// ============================================================================
`include "assert_macros.svh"

module circular_double_ended_queue #(
  parameter int DEPTH      = cdq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = cdq_pkg::DATA_W_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [cdq_pkg::CFG_W-1:0] cfg_wr_data,
  cdq_in_if.sink                    in_ch,
  cdq_out_if.source                 out_ch
);

  localparam int IDX_W  = $clog2(DEPTH);
  localparam int DCAP_W = $clog2(DEPTH + 1);
  localparam int CAP_W  = (DCAP_W > cdq_pkg::CFG_W) ? DCAP_W : cdq_pkg::CFG_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RESP = 1'b1;

  logic                      state_r, state_nxt;
  logic [cdq_pkg::CFG_W-1:0] cap_cfg_r;
  logic [IDX_W-1:0]          front_r, front_nxt;
  logic [IDX_W-1:0]          rear_r, rear_nxt;
  logic [cdq_pkg::CNT_W-1:0] count_r, count_nxt;

  // Result fields that are known at accept time, held for the collect cycle.
  cdq_pkg::status_t          res_status_r;
  logic [cdq_pkg::CNT_W-1:0] res_count_r;
  logic                      res_full_r;
  logic                      res_empty_r;
  logic                      res_pop_r;

  logic                      out_valid_r;
  cdq_pkg::status_t          out_status_r;
  logic [DATA_WIDTH-1:0]     out_popped_r;
  logic [cdq_pkg::CNT_W-1:0] out_count_r;
  logic                      out_full_r;
  logic                      out_empty_r;

  logic [CAP_W-1:0]      cap_ext, cap_eff, cap_m1;
  logic                  in_acc, out_load;
  logic                  is_full_now, is_empty_now;
  logic                  push_ok, pop_ok;
  logic [IDX_W-1:0]      front_fwd, front_back, rear_fwd, rear_back;
  logic [IDX_W-1:0]      mem_addr;
  logic                  mem_wr, mem_rd;
  logic [DATA_WIDTH-1:0] mem_rd_data;
  cdq_pkg::status_t      status_nxt;

  // --------------------------------------------------------------------------
  // Capacity clamp and index stepping
  // --------------------------------------------------------------------------
  always_comb begin
    cap_ext = CAP_W'(cap_cfg_r);
    if (cap_ext == '0) begin
      cap_eff = CAP_W'(1);
    end else if (cap_ext > CAP_W'(DEPTH)) begin
      cap_eff = CAP_W'(DEPTH);
    end else begin
      cap_eff = cap_ext;
    end
    cap_m1 = cap_eff - CAP_W'(1);
  end

  // An index left above the capacity after a capacity change steps forward to 0.
  assign front_fwd  = (CAP_W'(front_r) >= cap_m1) ? '0 : front_r + IDX_W'(1);
  assign rear_fwd   = (CAP_W'(rear_r) >= cap_m1) ? '0 : rear_r + IDX_W'(1);
  assign front_back = (front_r == '0) ? IDX_W'(cap_m1) : front_r - IDX_W'(1);
  assign rear_back  = (rear_r == '0) ? IDX_W'(cap_m1) : rear_r - IDX_W'(1);

  assign is_full_now  = CAP_W'(count_r) >= cap_eff;
  assign is_empty_now = count_r == '0;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_load    = (state_r == ST_RESP) && (!out_valid_r || out_ch.ready);

  // --------------------------------------------------------------------------
  // Operation decode: index and count updates, memory access
  // --------------------------------------------------------------------------
  always_comb begin
    front_nxt  = front_r;
    rear_nxt   = rear_r;
    count_nxt  = count_r;
    push_ok    = 1'b0;
    pop_ok     = 1'b0;
    mem_addr   = front_r;
    status_nxt = cdq_pkg::STAT_DONE;
    unique case (in_ch.opcode)
      cdq_pkg::OP_PUSH_FRONT: begin
        push_ok   = !is_full_now;
        mem_addr  = front_back;
        if (push_ok) begin
          front_nxt = front_back;
        end
      end
      cdq_pkg::OP_PUSH_REAR: begin
        push_ok  = !is_full_now;
        mem_addr = rear_r;
        if (push_ok) begin
          rear_nxt = rear_fwd;
        end
      end
      cdq_pkg::OP_POP_FRONT: begin
        pop_ok   = !is_empty_now;
        mem_addr = front_r;
        if (pop_ok) begin
          front_nxt = front_fwd;
        end
      end
      default: begin
        pop_ok   = !is_empty_now;
        mem_addr = rear_back;
        if (pop_ok) begin
          rear_nxt = rear_back;
        end
      end
    endcase
    if (push_ok) begin
      count_nxt = count_r + cdq_pkg::CNT_W'(1);
    end else if (pop_ok) begin
      count_nxt = count_r - cdq_pkg::CNT_W'(1);
    end
    if (!push_ok && !pop_ok) begin
      status_nxt = is_full_now && !in_ch.opcode[1] ? cdq_pkg::STAT_FULL
                                                   : cdq_pkg::STAT_EMPTY;
    end
  end

  // An operation is accepted only once the previous one has left the collect state,
  // so a write always lands before the next operation's read of the same entry.
  assign mem_wr = in_acc && push_ok;
  assign mem_rd = in_acc && pop_ok;

  cdq_ram #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_wr),
    .rd_en   (mem_rd),
    .addr    (mem_addr),
    .wr_data (in_ch.push_value),
    .rd_data (mem_rd_data)
  );

  // --------------------------------------------------------------------------
  // Controller and state registers
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_RESP;
        end
      end
      default: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cap_cfg_r <= cdq_pkg::CAP_RESET;
      front_r   <= '0;
      rear_r    <= '0;
      count_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        cap_cfg_r <= cfg_wr_data;
      end
      if (in_acc) begin
        front_r <= front_nxt;
        rear_r  <= rear_nxt;
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_status_r <= status_nxt;
      res_count_r  <= count_nxt;
      res_full_r   <= CAP_W'(count_nxt) >= cap_eff;
      res_empty_r  <= count_nxt == '0;
      res_pop_r    <= pop_ok;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= res_status_r;
      out_popped_r <= res_pop_r ? mem_rd_data : '0;
      out_count_r  <= res_count_r;
      out_full_r   <= res_full_r;
      out_empty_r  <= res_empty_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.popped_value  = out_popped_r;
  assign out_ch.element_count = out_count_r;
  assign out_ch.is_full       = out_full_r;
  assign out_ch.is_empty      = out_empty_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `CDQ_ASSERT_NEXT(a_accept_to_resp, in_acc, state_r == ST_RESP, "accept did not enter collect")
  `CDQ_ASSERT_IMPL(a_full_flag, out_valid_r && out_status_r == cdq_pkg::STAT_FULL, out_full_r, "full rejection without full flag")
  `CDQ_ASSERT_IMPL(a_empty_pop, out_valid_r && out_status_r == cdq_pkg::STAT_EMPTY, out_empty_r && out_popped_r == '0, "empty pop with data or flag clear")
  `CDQ_ASSERT_IMPL(a_empty_count, out_valid_r && out_empty_r, out_count_r == '0, "empty flag with nonzero count")

endmodule

[test/deque_checker.sv]
// ----------------------------------------------------------------------------
// Deque result checker
// Watches the operation and result channels of the deque, predicts each
// result from its own copy of the ring, indices, count and capacity, and
// compares every accepted result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module deque_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [cdq_pkg::CFG_W-1:0] cfg_wr_data,
  cdq_in_if                         in_mon,
  cdq_out_if                        out_mon,
  output int unsigned               mismatches,
  output int unsigned               results_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import cdq_pkg::*;

  typedef logic [DATA_W_DEF-1:0] word_t;

  typedef struct packed {
    status_t          status;
    word_t            popped_value;
    logic [CNT_W-1:0] element_count;
    logic             is_full;
    logic             is_empty;
  } deque_result_t;

  word_t            ring_copy [DEPTH_DEF];
  int unsigned      front_idx;
  int unsigned      rear_idx;
  int unsigned      held_words;
  logic [CFG_W-1:0] cap_setting;
  deque_result_t    pending_results [$];
  int unsigned      fail_count = 0;

  function automatic int unsigned step_fwd(int unsigned idx, int unsigned cap);
    return (idx >= cap - 1) ? 0 : idx + 1;
  endfunction

  function automatic int unsigned step_back(int unsigned idx, int unsigned cap);
    return (idx == 0) ? cap - 1 : idx - 1;
  endfunction

  // Applies one operation to the shadow deque and returns the result it gives.
  function automatic deque_result_t apply_deque_op(op_t op, word_t word);
    deque_result_t res;
    int unsigned   cap;
    logic          was_full;
    logic          was_empty;
    if (cap_setting == 0) begin
      cap = 1;
    end else if (cap_setting > DEPTH_DEF) begin
      cap = DEPTH_DEF;
    end else begin
      cap = cap_setting;
    end
    // A capacity lowered below the count still reads as full.
    was_full  = (held_words >= cap);
    was_empty = (held_words == 0);
    res = '0;
    res.status = STAT_DONE;
    case (op)
      OP_PUSH_FRONT: begin
        if (was_full) begin
          res.status = STAT_FULL;
        end else begin
          front_idx = step_back(front_idx, cap);
          ring_copy[front_idx] = word;
          held_words++;
        end
      end
      OP_PUSH_REAR: begin
        if (was_full) begin
          res.status = STAT_FULL;
        end else begin
          ring_copy[rear_idx] = word;
          rear_idx = step_fwd(rear_idx, cap);
          held_words++;
        end
      end
      OP_POP_FRONT: begin
        if (was_empty) begin
          res.status = STAT_EMPTY;
        end else begin
          res.popped_value = ring_copy[front_idx];
          front_idx = step_fwd(front_idx, cap);
          held_words--;
        end
      end
      default: begin
        if (was_empty) begin
          res.status = STAT_EMPTY;
        end else begin
          rear_idx = step_back(rear_idx, cap);
          res.popped_value = ring_copy[rear_idx];
          held_words--;
        end
      end
    endcase
    res.element_count = held_words[CNT_W-1:0];
    res.is_full       = (held_words >= cap);
    res.is_empty      = (held_words == 0);
    return res;
  endfunction

  task automatic report_failure(string msg);
    $display("%0t: deque check failed: %s", $realtime, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    deque_result_t want;
    if (!rst_n) begin
      front_idx   = 0;
      rear_idx    = 0;
      held_words  = 0;
      cap_setting = CAP_RESET;
      pending_results.delete();
      foreach (ring_copy[i]) ring_copy[i] = '0;
    end else begin
      if (cfg_wr_en) begin
        cap_setting = cfg_wr_data;
      end
      if (in_mon.valid && in_mon.ready) begin
        pending_results.push_back(apply_deque_op(in_mon.opcode, in_mon.push_value));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (pending_results.size() == 0) begin
          report_failure("result transaction with no operation outstanding");
        end else begin
          want = pending_results.pop_front();
          if (out_mon.status !== want.status) begin
            report_failure($sformatf("status expected %0d, got %0d",
                                     want.status, out_mon.status));
          end
          if (out_mon.popped_value !== want.popped_value) begin
            report_failure($sformatf("popped_value expected 0x%08h, got 0x%08h",
                                     want.popped_value, out_mon.popped_value));
          end
          if (out_mon.element_count !== want.element_count) begin
            report_failure($sformatf("element_count expected %0d, got %0d",
                                     want.element_count, out_mon.element_count));
          end
          if (out_mon.is_full !== want.is_full) begin
            report_failure($sformatf("is_full expected %0b, got %0b",
                                     want.is_full, out_mon.is_full));
          end
          if (out_mon.is_empty !== want.is_empty) begin
            report_failure($sformatf("is_empty expected %0b, got %0b",
                                     want.is_empty, out_mon.is_empty));
          end
        end
      end
    end
    mismatches      <= fail_count;
    results_pending <= pending_results.size();
  end

endmodule

[test/tb_circular_double_ended_queue.sv]
// ----------------------------------------------------------------------------
// Circular double-ended queue testbench
// Drives directed and random deque operations in bursts under a stalling
// receiver, changes the capacity between phases while the block is idle,
// and reports the verdict from the failure count of the deque checker.
// ----------------------------------------------------------------------------
module tb_circular_double_ended_queue;
  timeunit 1ns;
  timeprecision 1ps;

  import cdq_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 500000;
  localparam int unsigned NUM_PHASES    = 12;
  localparam int unsigned PHASE_ITEMS   = 166;
  localparam logic [CFG_W-1:0] CAP_PLAN [8] = '{5'd16, 5'd3, 5'd0, 5'd31,
                                                5'd1, 5'd17, 5'd2, 5'd16};
  localparam int unsigned PUSH_PCT [3] = '{80, 50, 20};

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [CFG_W-1:0] cfg_wr_data;
  int unsigned      mismatches;
  int unsigned      results_pending;
  int unsigned      cycle_count = 0;

  cdq_in_if  in_ch ();
  cdq_out_if out_ch ();

  circular_double_ended_queue i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  deque_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .mismatches      (mismatches),
    .results_pending (results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Presents one operation and returns at the edge that accepts it, with
  // valid still high so back-to-back transactions need no extra cycle.
  task automatic send_op(op_t op, logic [DATA_W_DEF-1:0] word);
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= op;
    in_ch.push_value <= word;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic pause_sender(int unsigned cycles);
    in_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Waits until every operation sent so far has returned its result.
  task automatic drain();
    pause_sender(1);
    while (results_pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CFG_W-1:0] cap);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // The receiver switches at random between stall patterns, from always ready to rarely ready.
  initial begin : receiver
    int unsigned mode;
    int unsigned span;
    out_ch.ready <= 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(32, 256);
      repeat (span) begin
        @(posedge clk);
        case (mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= ($urandom_range(0, 9) < 7);
          2:       out_ch.ready <= ($urandom_range(0, 9) < 3);
          default: out_ch.ready <= ($urandom_range(0, 15) == 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    int unsigned           push_pct;
    int unsigned           sent;
    int unsigned           burst;
    logic [CFG_W-1:0]      cap;
    op_t                   op;
    logic [DATA_W_DEF-1:0] word;
    rst_n            <= 1'b0;
    cfg_wr_en        <= 1'b0;
    cfg_wr_data      <= CAP_RESET;
    in_ch.valid      <= 1'b0;
    in_ch.opcode     <= OP_PUSH_FRONT;
    in_ch.push_value <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Pops from the empty deque, then a full pass of rear pushes so that
    // every slot of the ring holds a written word before anything is read.
    send_op(OP_POP_FRONT, 32'hFFFF_FFFF);
    send_op(OP_POP_REAR, 32'h0000_0000);
    for (int i = 0; i < DEPTH_DEF; i++) begin
      if (i == 0) begin
        send_op(OP_PUSH_REAR, 32'h0000_0000);
      end else if (i == 1) begin
        send_op(OP_PUSH_REAR, 32'hFFFF_FFFF);
      end else begin
        send_op(OP_PUSH_REAR, $urandom);
      end
    end
    // Pushes into the full deque are rejected; the rear pop wraps the rear
    // index back from zero and the last rear push wraps it forward to zero.
    send_op(OP_PUSH_FRONT, 32'hA5A5_5A5A);
    send_op(OP_PUSH_REAR, 32'h5A5A_A5A5);
    send_op(OP_POP_FRONT, 32'hFFFF_FFFF);
    send_op(OP_POP_REAR, 32'h0000_0000);
    send_op(OP_PUSH_FRONT, 32'hFFFF_FFFF);
    send_op(OP_PUSH_REAR, 32'h0000_0000);
    drain();

    // Content carries over between phases, so lowering the capacity below
    // the count and capacities out of range are both exercised.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase < $size(CAP_PLAN)) begin
        cap = CAP_PLAN[phase];
      end else begin
        cap = $urandom_range(0, 31);
      end
      write_capacity(cap);
      push_pct = PUSH_PCT[phase % 3];
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        burst = $urandom_range(1, 40);
        repeat (burst) begin
          if ($urandom_range(0, 99) < push_pct) begin
            op = $urandom_range(0, 1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
          end else begin
            op = $urandom_range(0, 1) ? OP_POP_REAR : OP_POP_FRONT;
          end
          case ($urandom_range(0, 7))
            0:       word = 32'h0000_0000;
            1:       word = 32'hFFFF_FFFF;
            default: word = $urandom;
          endcase
          send_op(op, word);
          sent++;
        end
        if ($urandom_range(0, 3) != 0) begin
          pause_sender($urandom_range(1, 12));
        end
      end
      drain();
    end

    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[circular_double_ended_queue.f]
+incdir+src
src/cdq_pkg.sv
src/cdq_in_if.sv
src/cdq_out_if.sv
src/cdq_ram.sv
src/circular_double_ended_queue.sv
test/deque_checker.sv
test/tb_circular_double_ended_queue.sv
